// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file b64d_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check at every edge, reset included.
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

  localparam int unsigned CHAR_W   = 16;
  localparam int unsigned COUNT_W  = 23;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = Q_PTR_W + 1;

  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = COUNT_W'(2097152);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  localparam logic CMD_CHAR    = 1'b0;
  localparam logic CMD_END     = 1'b1;
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY_LONG   = 3'd1,
    ST_BAD_PAD      = 3'd2,
    ST_BAD_CHAR     = 3'd3,
    ST_BAD_LEN      = 3'd4,
    ST_NOT_COOKIE   = 3'd5
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic       is_end;
    logic       is_pad;
    logic       is_bad;
    logic [5:0] sextet;
  } cls_item_t;

endpackage

// ===== hdl/b64d_front.sv =====
module b64d_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b64d_pkg::in_item_t   in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output b64d_pkg::cls_item_t  q_wdata
);

  logic [b64d_pkg::CHAR_W-1:0] c;
  logic [5:0]                  sx;
  logic                        bad;

  assign c = in_item.char_code;

  always_comb begin
    sx  = 6'd0;
    bad = 1'b0;
    priority if (c >= 16'h0041 && c <= 16'h005A) begin
      sx = 6'(c - 16'h0041);
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      sx = 6'(c - 16'h0061 + 16'd26);
    end else if (c >= 16'h0030 && c <= 16'h0039) begin
      sx = 6'(c - 16'h0030 + 16'd52);
    end else if (c == 16'h002D || c == 16'h002B) begin
      sx = 6'd62;
    end else if (c == 16'h005F || c == 16'h002F) begin
      sx = 6'd63;
    end else begin
      bad = 1'b1;
    end
  end

  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full;
  assign q_wdata.is_end = (in_item.cmd == b64d_pkg::CMD_END);
  assign q_wdata.is_pad = (c == 16'h003D);
  assign q_wdata.is_bad = bad;
  assign q_wdata.sextet = sx;

endmodule

// ===== hdl/b64d_queue.sv =====
module b64d_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64d_pkg::cls_item_t  wdata,
  output logic                 full,
  input  logic                 pop,
  output logic                 nonempty,
  output b64d_pkg::cls_item_t  rdata
);

  b64d_pkg::cls_item_t                 slot_r [b64d_pkg::Q_DEPTH];
  logic [b64d_pkg::Q_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::Q_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::Q_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                                do_pop;

  assign full     = (cnt_r == b64d_pkg::Q_CNT_W'(b64d_pkg::Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_pop   = pop && nonempty;
  assign rdata    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + b64d_pkg::Q_CNT_W'(push) - b64d_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
module b64d_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [b64d_pkg::COUNT_W-1:0]    cfg_data,
  input  logic                            q_nonempty,
  input  b64d_pkg::cls_item_t             q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output b64d_pkg::out_item_t             out_item
);

  localparam int unsigned HDR_LEN = 27;
  localparam logic [4:0]  HDR_LEN5 = 5'(HDR_LEN);
  localparam logic [4:0]  BYTE_SAT = 5'd28;
  localparam logic [7:0]  COOKIE_HDR [HDR_LEN] = '{
    8'h23, 8'h20, 8'h4E, 8'h65, 8'h74, 8'h73, 8'h63, 8'h61, 8'h70, 8'h65,
    8'h20, 8'h48, 8'h54, 8'h54, 8'h50, 8'h20, 8'h43, 8'h6F, 8'h6F, 8'h6B,
    8'h69, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65};

  logic [b64d_pkg::COUNT_W-1:0] max_r;
  logic [11:0]                  acc_r, acc_nxt;
  logic [3:0]                   pend_r, pend_nxt;
  logic                         pad_r, pad_nxt;
  b64d_pkg::status_t            err_r, err_nxt;
  logic [b64d_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]                   bcnt_r, bcnt_nxt;
  logic                         mism_r, mism_nxt;
  logic                         zero_r, zero_nxt;
  logic                         tab_r, tab_nxt;
  logic                         out_valid_r, out_valid_nxt;
  b64d_pkg::out_item_t          out_item_r, out_item_nxt;

  logic [b64d_pkg::COUNT_W-1:0] cap;
  logic [11:0]                  acc_sh;
  logic [3:0]                   pend_add;
  logic [3:0]                   pend_sub;
  logic [11:0]                  mask;
  logic [7:0]                   byte_v;
  logic [7:0]                   hdr_v;
  b64d_pkg::status_t            st;

  assign q_pop     = q_nonempty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    pad_nxt       = pad_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    bcnt_nxt      = bcnt_r;
    mism_nxt      = mism_r;
    zero_nxt      = zero_r;
    tab_nxt       = tab_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    cap      = (max_r == b64d_pkg::COUNT_MAX) ? max_r : max_r + 1'b1;
    acc_sh   = {acc_r[5:0], q_rdata.sextet};
    pend_add = pend_r + 4'd6;
    pend_sub = pend_add - 4'd8;
    byte_v   = 8'(acc_sh >> pend_sub);
    hdr_v    = (bcnt_r < HDR_LEN5) ? COOKIE_HDR[bcnt_r] : 8'h00;
    mask     = 12'((13'd1 << pend_r) - 13'd1);

    priority if (cnt_r == '0 || cnt_r > max_r) begin
      st = b64d_pkg::ST_EMPTY_LONG;
    end else if (err_r != b64d_pkg::ST_OK) begin
      st = err_r;
    end else if (pend_r == 4'd6 || (pend_r != 4'd0 && (acc_r & mask) != 12'd0)) begin
      st = b64d_pkg::ST_BAD_LEN;
    end else if (bcnt_r < BYTE_SAT || mism_r || zero_r || !tab_r) begin
      st = b64d_pkg::ST_NOT_COOKIE;
    end else begin
      st = b64d_pkg::ST_OK;
    end

    if (q_pop) begin
      if (q_rdata.is_end) begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.kind      = b64d_pkg::KIND_STATUS;
        out_item_nxt.data_byte = 8'h00;
        out_item_nxt.status    = 3'(st);
        acc_nxt                = '0;
        pend_nxt               = '0;
        pad_nxt                = 1'b0;
        err_nxt                = b64d_pkg::ST_OK;
        cnt_nxt                = '0;
        bcnt_nxt               = '0;
        mism_nxt               = 1'b0;
        zero_nxt               = 1'b0;
        tab_nxt                = 1'b0;
      end else begin
        if (cnt_r < cap) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (err_r == b64d_pkg::ST_OK && cnt_nxt <= max_r) begin
          priority if (q_rdata.is_pad) begin
            pad_nxt = 1'b1;
          end else if (pad_r) begin
            err_nxt = b64d_pkg::ST_BAD_PAD;
          end else if (q_rdata.is_bad) begin
            err_nxt = b64d_pkg::ST_BAD_CHAR;
          end else begin
            acc_nxt = acc_sh;
            if (pend_add >= 4'd8) begin
              pend_nxt               = pend_sub;
              out_valid_nxt          = 1'b1;
              out_item_nxt.kind      = b64d_pkg::KIND_DATA;
              out_item_nxt.data_byte = byte_v;
              out_item_nxt.status    = 3'(b64d_pkg::ST_OK);
              if (bcnt_r < HDR_LEN5 && byte_v != hdr_v) begin
                mism_nxt = 1'b1;
              end
              if (byte_v == 8'h00) begin
                zero_nxt = 1'b1;
              end
              if (byte_v == 8'h09) begin
                tab_nxt = 1'b1;
              end
              if (bcnt_r < BYTE_SAT) begin
                bcnt_nxt = bcnt_r + 1'b1;
              end
            end else begin
              pend_nxt = pend_add;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= b64d_pkg::MAX_CHARS_RESET;
      acc_r       <= '0;
      pend_r      <= '0;
      pad_r       <= 1'b0;
      err_r       <= b64d_pkg::ST_OK;
      cnt_r       <= '0;
      bcnt_r      <= '0;
      mism_r      <= 1'b0;
      zero_r      <= 1'b0;
      tab_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      pad_r       <= pad_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      bcnt_r      <= bcnt_nxt;
      mism_r      <= mism_nxt;
      zero_r      <= zero_nxt;
      tab_r       <= tab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hdl/base64url_payload_decoder_unit.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     in_item  (cmd, char_code)
// out      output     out_valid / out_stall   out_item (kind, data_byte, status)
// cfg      input      cfg_valid / cfg_ready   cfg_max_chars
//
// One transaction per cycle sustained while out_stall is low; the back end updates the accumulator
// and counters for one queued character per cycle while out_stall is low.
// An accepted input transaction is written into the queue, then decoded into the registered output.
// Reset sets max_chars to 2097152, clears the payload state and empties the queue.
// A four-entry queue between classification and decode absorbs out_stall;
// in_stall rises only when that queue is full. cfg_ready is always high.
module base64url_payload_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  b64d_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output b64d_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [b64d_pkg::COUNT_W-1:0] cfg_max_chars
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_nonempty;
  b64d_pkg::cls_item_t q_wdata;
  b64d_pkg::cls_item_t q_rdata;

  assign cfg_ready = 1'b1;

  b64d_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_max_chars),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/b64d_checker.sv =====
`include "assert_macros.svh"

module b64d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input b64d_pkg::out_item_t out_item
);

  `B64D_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled out transaction changed")
  `B64D_ASSERT(a_data_status_zero, out_valid && out_item.kind == b64d_pkg::KIND_DATA |-> out_item.status == 3'd0, "data transaction carries a status")
  `B64D_ASSERT(a_status_byte_zero, out_valid && out_item.kind == b64d_pkg::KIND_STATUS |-> out_item.data_byte == 8'h00, "status transaction carries a data byte")
  `B64D_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "out_valid high after reset")

endmodule

bind base64url_payload_decoder_unit b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== verif/b64d_payload_checker.sv =====
`timescale 1ns / 100ps

module b64d_payload_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  b64d_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  b64d_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [b64d_pkg::COUNT_W-1:0] cfg_max_chars,
  output int                           fail_count,
  output int                           outputs_awaited
);
  import b64d_pkg::*;

  localparam int HDR_LEN = 27;
  localparam int MIN_BYTES = 28;
  localparam logic [8*HDR_LEN-1:0] COOKIE_HDR = "# Netscape HTTP Cookie File";
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [15:0] CH_PAD = 16'h003D;

  logic [COUNT_W-1:0] limit_chars;
  logic [11:0]        acc;
  logic [3:0]         acc_bits;
  logic               pad_seen;
  status_t            char_err;
  logic [COUNT_W-1:0] n_chars;
  logic [4:0]         n_bytes;
  logic               hdr_bad;
  logic               zero_seen;
  logic               tab_seen;
  out_item_t          awaited_outputs[$];
  int                 n_fail = 0;

  initial begin
    fail_count = 0;
    outputs_awaited = 0;
  end

  // {valid, sextet}
  function automatic logic [6:0] sextet_of(logic [15:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
    if (c == "-" || c == "+") return {1'b1, 6'd62};
    if (c == "_" || c == "/") return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic void await_result(out_item_t r);
    awaited_outputs = {awaited_outputs, r};
  endfunction

  task automatic clear_payload();
    acc = '0;
    acc_bits = '0;
    pad_seen = 1'b0;
    char_err = ST_OK;
    n_chars = '0;
    n_bytes = '0;
    hdr_bad = 1'b0;
    zero_seen = 1'b0;
    tab_seen = 1'b0;
  endtask

  task automatic note_byte(logic [7:0] b);
    int idx;
    idx = int'(n_bytes);
    if (idx < HDR_LEN && b != COOKIE_HDR[8*(HDR_LEN-1-idx) +: 8]) hdr_bad = 1'b1;
    if (b == 8'h00) zero_seen = 1'b1;
    if (b == TAB_BYTE) tab_seen = 1'b1;
    if (idx < MIN_BYTES) n_bytes = n_bytes + 5'd1;
  endtask

  task automatic decode_item(in_item_t it);
    out_item_t          r;
    status_t            st;
    logic [11:0]        mask;
    logic [COUNT_W-1:0] cap;
    logic [6:0]         sx;
    logic [7:0]         b;
    if (it.cmd == CMD_END) begin
      mask = (12'h001 << acc_bits) - 12'h001;
      if (n_chars == '0 || n_chars > limit_chars) st = ST_EMPTY_LONG;
      else if (char_err != ST_OK) st = char_err;
      else if (acc_bits == 4'd6 || (acc_bits != 4'd0 && (acc & mask) != 12'h000))
        st = ST_BAD_LEN;
      else if (n_bytes < MIN_BYTES || hdr_bad || zero_seen || !tab_seen) st = ST_NOT_COOKIE;
      else st = ST_OK;
      r.kind = KIND_STATUS;
      r.data_byte = 8'h00;
      r.status = st;
      await_result(r);
      clear_payload();
      return;
    end
    cap = (limit_chars < COUNT_MAX) ? limit_chars + 1'b1 : COUNT_MAX;
    if (n_chars < cap) n_chars = n_chars + 1'b1;
    if (char_err != ST_OK || n_chars > limit_chars) return;
    if (it.char_code == CH_PAD) begin
      pad_seen = 1'b1;
      return;
    end
    if (pad_seen) begin
      char_err = ST_BAD_PAD;
      return;
    end
    sx = sextet_of(it.char_code);
    if (!sx[6]) begin
      char_err = ST_BAD_CHAR;
      return;
    end
    acc = {acc[5:0], sx[5:0]};
    acc_bits = acc_bits + 4'd6;
    if (acc_bits >= 4'd8) begin
      acc_bits = acc_bits - 4'd8;
      b = 8'(acc >> acc_bits);
      note_byte(b);
      r.kind = KIND_DATA;
      r.data_byte = b;
      r.status = 3'd0;
      await_result(r);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      limit_chars = MAX_CHARS_RESET;
      clear_payload();
      awaited_outputs.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_chars = cfg_max_chars;
      if (in_valid && !in_stall) decode_item(in_item);
      if (out_valid && !out_stall) begin
        if (awaited_outputs.size() == 0) begin
          $error("unexpected transaction: kind %0d data_byte %0h status %0d",
                 out_item.kind, out_item.data_byte, out_item.status);
          n_fail++;
        end else begin
          want = awaited_outputs.pop_front();
          if (out_item.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_item.kind);
            n_fail++;
          end
          if (out_item.data_byte !== want.data_byte) begin
            $error("data_byte mismatch: expected %0h, actual %0h",
                   want.data_byte, out_item.data_byte);
            n_fail++;
          end
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_item.status);
            n_fail++;
          end
        end
      end
    end
    fail_count <= n_fail;
    outputs_awaited <= awaited_outputs.size();
  end

endmodule

// ===== verif/tb_base64url_payload_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_base64url_payload_decoder_unit;
  import b64d_pkg::*;

  localparam int HDR_LEN = 27;
  localparam logic [8*HDR_LEN-1:0] COOKIE_HDR = "# Netscape HTTP Cookie File";
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [15:0] CH_PAD = 16'h003D;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 7;

  typedef enum int {FLAW_NONE, FLAW_AFTER_PAD, FLAW_BAD_CHAR, FLAW_TRUNCATE, FLAW_LOW_BITS} flaw_t;
  typedef enum int {DEFECT_ZERO, DEFECT_NO_TAB, DEFECT_HEADER, DEFECT_SHORT} defect_t;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_LONG} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_max_chars = '0;
  int                 fail_count;
  int                 outputs_awaited;

  int                 burst_left = 0;
  int                 items_sent = 0;
  int                 phase_budget[PHASES] = '{300, 60, 60, 300, 250, 250, 100};
  logic [7:0]         payload_bytes[$];
  logic [15:0]        payload_chars[$];
  stall_mode_t        stall_mode = STALL_NONE;
  int                 stall_left = 0;

  base64url_payload_decoder_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_max_chars (cfg_max_chars)
  );

  b64d_payload_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_chars   (cfg_max_chars),
    .fail_count      (fail_count),
    .outputs_awaited (outputs_awaited)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:   out_stall <= ($urandom_range(0, 1) == 1);
      default:      out_stall <= ((stall_left % 16) < 10);
    endcase
  end

  function automatic logic is_alpha(logic [15:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "+" || c == "_" || c == "/";
  endfunction

  function automatic logic [15:0] b64_char(logic [5:0] v);
    logic std_set;
    std_set = ($urandom_range(0, 1) == 1);
    if (v < 26) return 16'("A") + 16'(v);
    if (v < 52) return 16'("a") + 16'(v - 26);
    if (v < 62) return 16'("0") + 16'(v - 52);
    if (v == 62) return std_set ? 16'("+") : 16'("-");
    return std_set ? 16'("/") : 16'("_");
  endfunction

  function automatic logic [15:0] bad_code();
    logic [15:0] c;
    do begin
      case ($urandom_range(0, 2))
        0:       c = 16'($urandom_range(0, 65535));
        1:       c = 16'($urandom_range(0, 127));
        default: c = b64_char(6'($urandom_range(0, 63))) | (16'h0100 << $urandom_range(0, 7));
      endcase
    end while (is_alpha(c) || c == CH_PAD);
    return c;
  endfunction

  function automatic void add_char(logic [15:0] c);
    payload_chars = {payload_chars, c};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    payload_bytes = {payload_bytes, b};
  endfunction

  task automatic push_item(input logic cmd, input logic [15:0] code);
    in_item_t it;
    it.cmd = cmd;
    it.char_code = code;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outputs_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_max_chars <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(CMD_CHAR, {8'h00, s[i]});
    push_item(CMD_END, 16'h0000);
  endtask

  task automatic send_encoded(input flaw_t flaw);
    int          n;
    int          npad;
    logic [23:0] grp;
    logic [5:0]  last_s;
    payload_chars.delete();
    n = payload_bytes.size();
    last_s = '0;
    for (int i = 0; i < n; i += 3) begin
      grp = {payload_bytes[i], (i + 1 < n) ? payload_bytes[i + 1] : 8'h00,
             (i + 2 < n) ? payload_bytes[i + 2] : 8'h00};
      add_char(b64_char(grp[23:18]));
      last_s = grp[17:12];
      add_char(b64_char(last_s));
      if (i + 1 < n) begin
        last_s = grp[11:6];
        add_char(b64_char(last_s));
      end
      if (i + 2 < n) begin
        last_s = grp[5:0];
        add_char(b64_char(last_s));
      end
    end
    npad = (3 - n % 3) % 3;
    case (flaw)
      FLAW_LOW_BITS: begin
        if (payload_chars.size() != 0)
          payload_chars[payload_chars.size() - 1] = b64_char(last_s ^ 6'd1);
      end
      FLAW_TRUNCATE: begin
        repeat ($urandom_range(1, 3))
          if (payload_chars.size() != 0) void'(payload_chars.pop_back());
      end
      FLAW_BAD_CHAR: begin
        if (payload_chars.size() != 0)
          payload_chars[$urandom_range(0, payload_chars.size() - 1)] = bad_code();
        else
          add_char(bad_code());
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1)
      repeat (npad + $urandom_range(0, 1)) add_char(CH_PAD);
    if (flaw == FLAW_AFTER_PAD) begin
      add_char(CH_PAD);
      add_char(($urandom_range(0, 1) == 1) ?
               b64_char(6'($urandom_range(0, 63))) : bad_code());
    end
    foreach (payload_chars[k]) push_item(CMD_CHAR, payload_chars[k]);
    push_item(CMD_END, 16'($urandom));
  endtask

  task automatic send_payload();
    int    sel;
    int    n;
    int    idx;
    flaw_t flaw;
    payload_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      for (int i = 0; i < HDR_LEN; i++)
        add_byte(COOKIE_HDR[8*(HDR_LEN-1-i) +: 8]);
      n = $urandom_range(1, 12);
      repeat (n) add_byte(8'($urandom_range(1, 255)));
      payload_bytes[HDR_LEN + $urandom_range(0, n - 1)] = TAB_BYTE;
      if (sel >= 40) begin
        case (defect_t'($urandom_range(0, 3)))
          DEFECT_ZERO:   payload_bytes[$urandom_range(0, payload_bytes.size() - 1)] = 8'h00;
          DEFECT_NO_TAB: begin
            foreach (payload_bytes[k])
              if (payload_bytes[k] == TAB_BYTE) payload_bytes[k] = 8'h20;
          end
          DEFECT_HEADER: begin
            idx = $urandom_range(0, HDR_LEN - 1);
            payload_bytes[idx] = payload_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
          end
          default: repeat ($urandom_range(1, n + 7)) void'(payload_bytes.pop_back());
        endcase
      end
    end else if (sel < 88) begin
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 3))
          0:       push_item(CMD_CHAR, b64_char(6'($urandom_range(0, 63))));
          1:       push_item(CMD_CHAR, CH_PAD);
          2:       push_item(CMD_CHAR, bad_code());
          default: push_item(CMD_CHAR, 16'($urandom));
        endcase
      end
      push_item(CMD_END, 16'($urandom));
      return;
    end
    flaw = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
    send_encoded(flaw);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("");
    send_text("AZaz09-_");
    send_text("+/==");
    send_text("QQ=A");
    send_text("A");
    push_item(CMD_CHAR, 16'hFFFF);
    push_item(CMD_CHAR, 16'h0000);
    push_item(CMD_END, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       write_limit(23'd1);
        2:       write_limit(23'd0);
        3:       write_limit(COUNT_MAX);
        4:       write_limit(23'd4194304);
        5:       write_limit(23'($urandom_range(36, 70)));
        6:       write_limit(23'($urandom_range(2, 8)));
        default: ;
      endcase
      target = items_sent + phase_budget[p];
      while (items_sent < target) send_payload();
    end

    drain();
    @(negedge clk);
    if (fail_count == 0 && outputs_awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
